// File: src/trq_pkg.sv
package trq_pkg;

    localparam int TASKS  = 64;
    localparam int ID_W   = $clog2(TASKS);
    localparam int PTR_W  = ID_W + 1;
    localparam int TIME_W = 32;

    localparam logic [PTR_W-1:0] NO_TASK = PTR_W'(TASKS);

    // task status codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_TERM = 2'd2;

    // commands
    localparam logic [1:0] CMD_INSERT   = 2'd0;
    localparam logic [1:0] CMD_REMOVE   = 2'd1;
    localparam logic [1:0] CMD_CANCEL   = 2'd2;
    localparam logic [1:0] CMD_DISPATCH = 2'd3;

    // error codes
    localparam logic [2:0] ERR_OK      = 3'd0;
    localparam logic [2:0] ERR_TERM    = 3'd1;
    localparam logic [2:0] ERR_RUNNING = 3'd2;
    localparam logic [2:0] ERR_NEG     = 3'd3;
    localparam logic [2:0] ERR_QUEUED  = 3'd4;
    localparam logic [2:0] ERR_CLKBUSY = 3'd5;

    // config register indexes
    localparam logic [1:0] CFG_START = 2'd0;
    localparam logic [1:0] CFG_CLKEN = 2'd1;
    localparam logic [1:0] CFG_CLKID = 2'd2;

    // datapath operations
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_LOAD     = 4'd1;
    localparam logic [3:0] OP_CHK      = 4'd2;
    localparam logic [3:0] OP_RD_Q     = 4'd3;
    localparam logic [3:0] OP_STEP     = 4'd4;
    localparam logic [3:0] OP_INS_LINK = 4'd5;
    localparam logic [3:0] OP_INS_PREV = 4'd6;
    localparam logic [3:0] OP_UNLINK   = 4'd7;
    localparam logic [3:0] OP_DISP     = 4'd8;
    localparam logic [3:0] OP_FIN      = 4'd9;
    localparam logic [3:0] OP_OUT      = 4'd10;
    localparam logic [3:0] OP_RDO      = 4'd11;

    typedef struct packed {
        logic [3:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       head_none;
        logic       ins_err;
        logic       onq_id;
        logic       q_is_id;
        logic       t_lt;
        logic       lk_none;
        logic       out_free;
    } t_dp_stat;

endpackage

// File: src/trq_ram.sv
module trq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: src/trq_ctrl.sv
module trq_ctrl
    import trq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_fire,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_EV   = 4'd3;
    localparam logic [3:0] S_LNK  = 4'd4;
    localparam logic [3:0] S_PRV  = 4'd5;
    localparam logic [3:0] S_FIN  = 4'd6;
    localparam logic [3:0] S_RDO  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // sequencer
    always_comb begin
        n_state   = r_state;
        o_cmd.op  = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_fire) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                unique case (i_stat.cmd)
                    CMD_INSERT: begin
                        o_cmd.op = OP_CHK;
                        if (i_stat.ins_err) n_state = S_RDO;
                        else if (i_stat.head_none) n_state = S_LNK;
                        else n_state = S_RD;
                    end
                    CMD_DISPATCH: begin
                        n_state = i_stat.head_none ? S_RDO : S_RD;
                    end
                    default: begin
                        n_state = i_stat.onq_id ? S_RD : S_FIN;
                    end
                endcase
            end
            S_RD: begin
                o_cmd.op = OP_RD_Q;
                n_state  = S_EV;
            end
            S_EV: begin
                unique case (i_stat.cmd)
                    CMD_INSERT: begin
                        if (i_stat.t_lt) begin
                            n_state = S_LNK;
                        end else begin
                            o_cmd.op = OP_STEP;
                            n_state  = i_stat.lk_none ? S_LNK : S_RD;
                        end
                    end
                    CMD_DISPATCH: begin
                        o_cmd.op = OP_DISP;
                        n_state  = S_RDO;
                    end
                    default: begin
                        if (i_stat.q_is_id) begin
                            o_cmd.op = OP_UNLINK;
                            n_state  = S_FIN;
                        end else begin
                            o_cmd.op = OP_STEP;
                            n_state  = S_RD;
                        end
                    end
                endcase
            end
            S_LNK: begin
                o_cmd.op = OP_INS_LINK;
                n_state  = S_PRV;
            end
            S_PRV: begin
                o_cmd.op = OP_INS_PREV;
                n_state  = S_FIN;
            end
            S_FIN: begin
                o_cmd.op = OP_FIN;
                n_state  = S_RDO;
            end
            S_RDO: begin
                o_cmd.op = OP_RDO;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: src/trq_dp.sv
module trq_dp
    import trq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic [71:0]       i_item,
    input  logic              i_cfg_fire,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [79:0]       o_out_data
);

    // config and scheduler state
    logic              r_clk_en;
    logic [ID_W-1:0]   r_clk_id;
    logic [TIME_W-1:0] r_clock;
    logic [PTR_W-1:0]  r_head;
    logic [PTR_W-1:0]  r_current;
    logic [1:0]        r_status [TASKS];
    logic [TASKS-1:0]  r_onq;

    // item and walk registers
    logic [1:0]        r_cmd;
    logic [ID_W-1:0]   r_id;
    logic [31:0]       r_delay;
    logic [31:0]       r_res;
    logic [PTR_W-1:0]  r_prev;
    logic [PTR_W-1:0]  r_q;
    logic [PTR_W-1:0]  r_addr;
    logic [PTR_W-1:0]  r_chosen;
    logic [2:0]        r_err;

    // registered status reads: {on queue, status} of one task, clock task busy
    logic [2:0]        r_sid;
    logic              r_sck;
    logic [ID_W-1:0]   st_ra;

    // memories
    logic              link_we;
    logic [ID_W-1:0]   link_wa;
    logic [PTR_W-1:0]  link_wd;
    logic [PTR_W-1:0]  link_rd;
    logic              time_we;
    logic [TIME_W-1:0] time_wd;
    logic [TIME_W-1:0] time_rd;
    logic [ID_W-1:0]   rd_addr;

    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] t_wake;
    logic [2:0]        ins_err;
    logic [1:0]        id_st;
    logic              adv;
    logic              addr_ok;

    assign rd_addr = (i_cmd.op == OP_RD_Q) ? r_q[ID_W-1:0] : r_addr[ID_W-1:0];

    trq_ram #(.WIDTH(PTR_W), .DEPTH(TASKS)) u_link (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_wa),
        .i_wdata (link_wd),
        .i_raddr (rd_addr),
        .o_rdata (link_rd)
    );

    trq_ram #(.WIDTH(TIME_W), .DEPTH(TASKS)) u_time (
        .i_clk   (i_clk),
        .i_we    (time_we),
        .i_waddr (r_id),
        .i_wdata (time_wd),
        .i_raddr (rd_addr),
        .o_rdata (time_rd)
    );

    // status read: item's task on load, addressed task before the result
    assign st_ra = (i_cmd.op == OP_LOAD) ? i_item[7:2] : r_addr[ID_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD || i_cmd.op == OP_RDO) begin
            r_sid <= {r_onq[st_ra], r_status[st_ra]};
        end
        if (i_cmd.op == OP_LOAD) begin
            r_sck <= (r_status[r_clk_id] != ST_IDLE);
        end
    end

    // saturating wake time
    assign sum    = {1'b0, r_clock} + {1'b0, r_delay};
    assign t_wake = sum[TIME_W] ? '1 : sum[TIME_W-1:0];

    // insert checks, in priority order
    assign id_st = r_sid[1:0];
    always_comb begin
        priority if (id_st == ST_TERM) ins_err = ERR_TERM;
        else if (id_st == ST_RUN && {1'b0, r_id} != r_current) ins_err = ERR_RUNNING;
        else if (r_delay[31]) ins_err = ERR_NEG;
        else if (r_sid[2]) ins_err = ERR_QUEUED;
        else ins_err = ERR_OK;
    end

    assign adv = time_rd > r_clock;

    always_comb begin
        o_stat.cmd       = r_cmd;
        o_stat.head_none = (r_head == NO_TASK);
        o_stat.ins_err   = (ins_err != ERR_OK);
        o_stat.onq_id    = r_sid[2];
        o_stat.q_is_id   = (r_q == {1'b0, r_id});
        o_stat.t_lt      = t_wake < time_rd;
        o_stat.lk_none   = (link_rd == NO_TASK);
        o_stat.out_free  = !o_out_valid || i_out_ready;
    end

    // memory writes
    always_comb begin
        link_we = 1'b0;
        link_wa = r_id;
        link_wd = r_q;
        time_we = 1'b0;
        time_wd = t_wake;
        unique case (i_cmd.op)
            OP_INS_LINK: link_we = 1'b1;
            OP_INS_PREV: begin
                link_we = (r_prev != NO_TASK);
                link_wa = r_prev[ID_W-1:0];
                link_wd = {1'b0, r_id};
            end
            OP_UNLINK: begin
                link_we = (r_prev != NO_TASK);
                link_wa = r_prev[ID_W-1:0];
                link_wd = link_rd;
            end
            OP_FIN: begin
                time_we = (r_cmd == CMD_INSERT) || (r_cmd == CMD_CANCEL);
                time_wd = (r_cmd == CMD_CANCEL) ? r_res : t_wake;
            end
            default: ;
        endcase
    end

    // item registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_cmd    <= i_item[1:0];
                r_id     <= i_item[7:2];
                r_delay  <= i_item[39:8];
                r_res    <= i_item[71:40];
                r_prev   <= NO_TASK;
                r_q      <= r_head;
                r_addr   <= (i_item[1:0] == CMD_DISPATCH) ? NO_TASK : {1'b0, i_item[7:2]};
                r_chosen <= NO_TASK;
                r_err    <= ERR_OK;
            end
            OP_CHK: r_err <= ins_err;
            OP_STEP: begin
                r_prev <= r_q;
                r_q    <= link_rd;
            end
            OP_DISP: begin
                if (adv && r_clk_en && r_sck) begin
                    r_err <= ERR_CLKBUSY;
                end else if (adv && r_clk_en) begin
                    r_chosen <= {1'b0, r_clk_id};
                    r_addr   <= {1'b0, r_clk_id};
                end else begin
                    r_chosen <= r_q;
                    r_addr   <= r_q;
                end
            end
            default: ;
        endcase
    end

    // scheduler state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_en  <= 1'b0;
            r_clk_id  <= '0;
            r_clock   <= '0;
            r_head    <= NO_TASK;
            r_current <= NO_TASK;
            r_onq     <= '0;
            for (int i = 0; i < TASKS; i++) begin
                r_status[i] <= ST_IDLE;
            end
        end else begin
            if (i_cfg_fire) begin
                unique case (i_cfg_index)
                    CFG_START: r_clock  <= i_cfg_data;
                    CFG_CLKEN: r_clk_en <= i_cfg_data[0];
                    CFG_CLKID: r_clk_id <= i_cfg_data[ID_W-1:0];
                    default: ;
                endcase
            end
            unique case (i_cmd.op)
                OP_INS_PREV: begin
                    if (r_prev == NO_TASK) r_head <= {1'b0, r_id};
                end
                OP_UNLINK: begin
                    if (r_prev == NO_TASK) r_head <= link_rd;
                end
                OP_DISP: begin
                    if (!(adv && r_clk_en && r_sck)) begin
                        if (adv) r_clock <= time_rd;
                        if (adv && r_clk_en) begin
                            r_current <= {1'b0, r_clk_id};
                        end else begin
                            r_current <= r_q;
                            r_head    <= link_rd;
                            r_onq[r_q[ID_W-1:0]] <= 1'b0;
                        end
                    end
                end
                OP_FIN: begin
                    unique case (r_cmd)
                        CMD_INSERT: begin
                            r_status[r_id] <= ST_RUN;
                            r_onq[r_id]    <= 1'b1;
                        end
                        CMD_REMOVE: begin
                            r_status[r_id] <= ST_IDLE;
                            r_onq[r_id]    <= 1'b0;
                        end
                        CMD_CANCEL: begin
                            r_status[r_id] <= ST_TERM;
                            r_onq[r_id]    <= 1'b0;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // output register
    assign addr_ok = (r_addr != NO_TASK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_OUT) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_OUT) begin
            o_out_data[2:0]   <= r_err;
            o_out_data[3]     <= (r_chosen != NO_TASK);
            o_out_data[9:4]   <= (r_chosen != NO_TASK) ? r_chosen[ID_W-1:0] : '0;
            o_out_data[10]    <= (r_head == NO_TASK);
            o_out_data[42:11] <= r_clock;
            o_out_data[44:43] <= addr_ok ? r_sid[1:0] : ST_IDLE;
            o_out_data[76:45] <= addr_ok ? time_rd : '0;
            o_out_data[79:77] <= '0;
        end
    end

endmodule

// File: src/time_ordered_run_queue_core.sv
// Time-ordered run queue for 64 tasks. One input item is one command (insert,
// remove, cancel, dispatch) and yields exactly one result item. Queued tasks sit
// in a linked list held in a 64-entry link RAM, sorted by wake time; sorted insert
// and unlink walk that list one node at a time (registered RAM read, then
// compare), so errors and empty dispatches take the shortest path, and an
// insert behind 63 queued tasks or a remove of the last of 64 the longest.
// One item is in work at a time; the next one is taken while the previous
// result waits at the output.
// Configuration writes are taken at any time but are meant for idle periods.
module time_ordered_run_queue_core
    import trq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // cmd[1:0], task_id[7:2], delay[39:8], result_value[71:40]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,  // error[2:0], chosen_valid[3], chosen_id[9:4],
                                       // queue_empty[10], clock_now[42:11],
                                       // task_state[44:43], task_word[76:45], zero fill
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    trq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (s_axis_tvalid && s_axis_tready),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    trq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_item      (s_axis_tdata),
        .i_cfg_fire  (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// File: src/trq_checker.sv
module trq_checker
    import trq_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a picked task never comes with an error
    a_pick_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2:0] == ERR_OK)
        else $error("dispatch pick with error");

    // no pick means id zero
    a_nopick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[3] |-> m_axis_tdata[9:4] == '0)
        else $error("chosen id without pick");

    // error codes stay in range
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= ERR_CLKBUSY)
        else $error("bad error code");

endmodule

bind time_ordered_run_queue_core trq_checker u_trq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import trq_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // cmd, task_id, delay, result_value
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;   // error, chosen_valid, chosen_id, queue_empty,
                                 // clock_now, task_state, task_word
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    // packed from the top bit down, so err lands in the lowest bits
    typedef struct packed {
        logic [31:0] task_word;
        logic [1:0]  task_state;
        logic [31:0] clock_now;
        logic        queue_empty;
        logic [5:0]  chosen_id;
        logic        chosen_valid;
        logic [2:0]  err;
    } sched_result_t;

    time_ordered_run_queue_core uut (.*);

    // scheduler shadow state
    logic [31:0]      sh_clock;
    logic [PTR_W-1:0] sh_head;
    logic [PTR_W-1:0] sh_link [TASKS];
    logic [1:0]       sh_status [TASKS];
    logic [31:0]      sh_time [TASKS];
    logic [PTR_W-1:0] sh_current;
    logic             sh_clk_en;
    logic [5:0]       sh_clk_id;
    bit               sh_written [TASKS];

    sched_result_t pending_results[$];
    int  errors;
    int  cycles;
    bit  rx_stall_mode;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver stall pattern: alternating quiet and choppy stretches
    always @(posedge i_clk) begin
        if (cycles % 500 == 0)
            rx_stall_mode <= ~rx_stall_mode;
        m_axis_tready <= rx_stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
    end

    // result checker
    always @(posedge i_clk) begin
        sched_result_t got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = sched_result_t'(m_axis_tdata[76:0]);
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.err !== want.err) begin
                    $display("%0t: error exp %0d got %0d", $realtime, want.err, got.err);
                    errors++;
                end
                if (got.chosen_valid !== want.chosen_valid) begin
                    $display("%0t: chosen_valid exp %0d got %0d", $realtime,
                             want.chosen_valid, got.chosen_valid);
                    errors++;
                end
                if (got.chosen_id !== want.chosen_id) begin
                    $display("%0t: chosen_id exp %0d got %0d", $realtime,
                             want.chosen_id, got.chosen_id);
                    errors++;
                end
                if (got.queue_empty !== want.queue_empty) begin
                    $display("%0t: queue_empty exp %0d got %0d", $realtime,
                             want.queue_empty, got.queue_empty);
                    errors++;
                end
                if (got.clock_now !== want.clock_now) begin
                    $display("%0t: clock_now exp %h got %h", $realtime,
                             want.clock_now, got.clock_now);
                    errors++;
                end
                if (got.task_state !== want.task_state) begin
                    $display("%0t: task_state exp %0d got %0d", $realtime,
                             want.task_state, got.task_state);
                    errors++;
                end
                if (got.task_word !== want.task_word) begin
                    $display("%0t: task_word exp %h got %h", $realtime,
                             want.task_word, got.task_word);
                    errors++;
                end
            end
        end
    end

    function automatic void shadow_reset();
        sh_clock = '0;
        sh_head = NO_TASK;
        sh_current = NO_TASK;
        sh_clk_en = 1'b0;
        sh_clk_id = '0;
        for (int i = 0; i < TASKS; i++) begin
            sh_link[i] = NO_TASK;
            sh_status[i] = ST_IDLE;
            sh_time[i] = '0;
            sh_written[i] = 1'b0;
        end
    endfunction

    function automatic bit queued(logic [ID_W-1:0] id);
        logic [PTR_W-1:0] p;
        p = sh_head;
        for (int n = 0; n < TASKS && p != NO_TASK; n++) begin
            if (p == {1'b0, id}) return 1'b1;
            p = sh_link[p[ID_W-1:0]];
        end
        return 1'b0;
    endfunction

    function automatic void unlink(logic [ID_W-1:0] id);
        logic [PTR_W-1:0] p;
        p = sh_head;
        if (p == NO_TASK) return;
        if (p == {1'b0, id}) begin
            sh_head = sh_link[id];
            sh_link[id] = NO_TASK;
            return;
        end
        for (int n = 0; n < TASKS && sh_link[p[ID_W-1:0]] != NO_TASK; n++) begin
            if (sh_link[p[ID_W-1:0]] == {1'b0, id}) begin
                sh_link[p[ID_W-1:0]] = sh_link[id];
                sh_link[id] = NO_TASK;
                return;
            end
            p = sh_link[p[ID_W-1:0]];
        end
    endfunction

    function automatic void link_sorted(logic [ID_W-1:0] id, logic [31:0] t);
        logic [PTR_W-1:0] p;
        p = sh_head;
        if (p == NO_TASK || t < sh_time[p[ID_W-1:0]]) begin
            sh_link[id] = p;
            sh_head = {1'b0, id};
            return;
        end
        for (int n = 0; n < TASKS && sh_link[p[ID_W-1:0]] != NO_TASK; n++) begin
            if (t < sh_time[sh_link[p[ID_W-1:0]][ID_W-1:0]]) break;
            p = sh_link[p[ID_W-1:0]];
        end
        sh_link[id] = sh_link[p[ID_W-1:0]];
        sh_link[p[ID_W-1:0]] = {1'b0, id};
    endfunction

    // works out the result of one scheduler command and updates the shadow
    function automatic sched_result_t schedule_cmd(logic [1:0] cmd, logic [5:0] id,
                                                    logic [31:0] dly, logic [31:0] res);
        sched_result_t r;
        logic [PTR_W-1:0] p, chosen, addr;
        logic [32:0] sum;
        logic [31:0] tt;
        r = '0;
        chosen = NO_TASK;
        addr = {1'b0, id};
        if (cmd == CMD_DISPATCH) begin
            p = sh_head;
            addr = NO_TASK;
            if (p != NO_TASK) begin
                tt = sh_time[p[ID_W-1:0]];
                if (tt > sh_clock && sh_clk_en && sh_status[sh_clk_id] != ST_IDLE) begin
                    r.err = ERR_CLKBUSY;
                end else begin
                    if (tt > sh_clock && sh_clk_en) begin
                        sh_clock = tt;
                        chosen = {1'b0, sh_clk_id};
                    end else begin
                        if (tt > sh_clock) sh_clock = tt;
                        sh_head = sh_link[p[ID_W-1:0]];
                        sh_link[p[ID_W-1:0]] = NO_TASK;
                        chosen = p;
                    end
                    sh_current = chosen;
                    addr = chosen;
                end
            end
        end else if (cmd == CMD_INSERT) begin
            if (sh_status[id] == ST_TERM) r.err = ERR_TERM;
            else if (sh_status[id] == ST_RUN && {1'b0, id} != sh_current) r.err = ERR_RUNNING;
            else if (dly[31]) r.err = ERR_NEG;
            else if (queued(id)) r.err = ERR_QUEUED;
            else begin
                sum = {1'b0, sh_clock} + {1'b0, dly};
                tt = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                sh_time[id] = tt;
                sh_written[id] = 1'b1;
                sh_status[id] = ST_RUN;
                link_sorted(id, tt);
            end
        end else if (cmd == CMD_REMOVE) begin
            unlink(id);
            sh_status[id] = ST_IDLE;
        end else begin
            if (sh_status[id] == ST_RUN) unlink(id);
            sh_status[id] = ST_TERM;
            sh_time[id] = res;
            sh_written[id] = 1'b1;
        end
        r.chosen_valid = (chosen != NO_TASK);
        r.chosen_id = (chosen != NO_TASK) ? chosen[5:0] : '0;
        r.queue_empty = (sh_head == NO_TASK);
        r.clock_now = sh_clock;
        if (addr != NO_TASK) begin
            r.task_state = sh_status[addr[ID_W-1:0]];
            r.task_word = sh_time[addr[ID_W-1:0]];
        end
        return r;
    endfunction

    // sends one command item, with a random gap first when bursting ends
    int burst_left;
    task automatic send_cmd(logic [1:0] cmd, logic [5:0] id, logic [31:0] dly,
                            logic [31:0] res);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {res, dly, id, cmd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(schedule_cmd(cmd, id, dly, res));
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_START) sh_clock = val;
        else if (idx == CFG_CLKEN) sh_clk_en = val[0];
        else sh_clk_id = val[5:0];
        @(posedge i_clk);
    endtask

    // every task's time word is written once at the start, so no later read
    // returns undefined state.
    function automatic logic [5:0] pick_id(int span);
        return 6'($urandom_range(0, span - 1));
    endfunction

    // insert and remove each task once so its time word is defined
    task automatic test_init();
        for (int i = 0; i < TASKS; i++) begin
            if (!sh_written[i]) send_cmd(CMD_INSERT, 6'(i), 0, 0);
        end
        for (int i = 0; i < TASKS; i++) begin
            send_cmd(CMD_REMOVE, 6'(i), 0, 0);
        end
        drain();
    endtask

    task automatic test_directed();
        send_cmd(CMD_DISPATCH, 0, 0, 0);                 // empty queue
        send_cmd(CMD_INSERT, 63, 32'h7FFF_FFFF, 0);
        send_cmd(CMD_INSERT, 0, 0, 0);
        send_cmd(CMD_INSERT, 1, 0, 0);                   // equal time, arrival order
        send_cmd(CMD_INSERT, 2, 32'h8000_0000, 0);       // negative delay
        send_cmd(CMD_INSERT, 0, 5, 0);                   // running, not current
        send_cmd(CMD_DISPATCH, 0, 0, 0);
        send_cmd(CMD_INSERT, 0, 5, 0);                   // current but queued? no: popped
        send_cmd(CMD_INSERT, 0, 6, 0);                   // already queued
        send_cmd(CMD_CANCEL, 1, 0, 32'hFFFF_FFFF);       // cancel queued
        send_cmd(CMD_INSERT, 1, 3, 0);                   // terminated
        send_cmd(CMD_REMOVE, 1, 0, 0);                   // terminated back to idle
        send_cmd(CMD_REMOVE, 40, 0, 0);                  // not queued
        send_cmd(CMD_DISPATCH, 0, 0, 0);
        send_cmd(CMD_DISPATCH, 0, 0, 0);                 // clock jumps far
        send_cmd(CMD_INSERT, 5, 32'h7FFF_FFFF, 0);       // wake time near the top, not saturated
        send_cmd(CMD_DISPATCH, 0, 0, 0);
        send_cmd(CMD_CANCEL, 63, 0, 32'h0);
        send_cmd(CMD_REMOVE, 63, 0, 0);
        drain();
    endtask

    task automatic test_clock_task();
        write_reg(CFG_START, 32'd100);
        write_reg(CFG_CLKID, 32'd63);
        write_reg(CFG_CLKEN, 32'd1);
        send_cmd(CMD_REMOVE, 63, 0, 0);
        send_cmd(CMD_REMOVE, 5, 0, 0);
        send_cmd(CMD_INSERT, 10, 50, 0);
        send_cmd(CMD_DISPATCH, 0, 0, 0);                 // clock task chosen
        send_cmd(CMD_INSERT, 11, 70, 0);
        send_cmd(CMD_DISPATCH, 0, 0, 0);                 // popped without advance
        send_cmd(CMD_INSERT, 63, 9, 0);                  // clock task now queued
        send_cmd(CMD_DISPATCH, 0, 0, 0);                 // clock task busy
        drain();
        write_reg(CFG_START, 32'd0);                     // clock set below the queued wake time
        send_cmd(CMD_DISPATCH, 0, 0, 0);
        drain();
        write_reg(CFG_START, 32'hFFFF_FFF0);
        send_cmd(CMD_REMOVE, 63, 0, 0);
        send_cmd(CMD_INSERT, 20, 32'h100, 0);            // saturates
        send_cmd(CMD_DISPATCH, 0, 0, 0);
        drain();
    endtask

    task automatic random_phase(int n, int span);
        logic [1:0] cmd;
        logic [31:0] dly;
        for (int i = 0; i < n; i++) begin
            cmd = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 9) < 4) cmd = CMD_INSERT;
            else if ($urandom_range(0, 9) < 4) cmd = CMD_DISPATCH;
            case ($urandom_range(0, 9))
                0: dly = $urandom();
                1: dly = 32'h7FFF_FFFF - $urandom_range(0, 3);
                2: dly = 0;
                default: dly = $urandom_range(0, 200);
            endcase
            send_cmd(cmd, pick_id(span), dly, $urandom());
        end
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_START, (ph == 5) ? 32'hFFFF_FF00 : $urandom_range(0, 1000));
            write_reg(CFG_CLKEN, ph % 2);
            write_reg(CFG_CLKID, (ph == 3) ? 32'd63 : $urandom_range(0, 15));
            random_phase(ph == 4 ? 60 : 160, ph == 4 ? 64 : 16);
            drain();   // sender pauses until every result is in
        end
    endtask

    initial begin
        i_clk = 0;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        m_axis_tready = 0;
        i_cfg_valid = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        errors = 0;
        cycles = 0;
        rx_stall_mode = 0;
        burst_left = 0;
        shadow_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_init();
        test_directed();
        test_clock_task();
        test_random();
        if (errors == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: time_ordered_run_queue_core.f
src/trq_pkg.sv
src/trq_ram.sv
src/trq_ctrl.sv
src/trq_dp.sv
src/time_ordered_run_queue_core.sv
src/trq_checker.sv
sim/tb.sv
